@@ rtl/core/iecq_pkg.sv @@
`default_nettype none
package iecq_pkg;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned MAX_KEYS = 31;

  localparam logic [2:0] OP_KEY    = 3'd0;
  localparam logic [2:0] OP_MOVE   = 3'd1;
  localparam logic [2:0] OP_BUTTON = 3'd2;
  localparam logic [2:0] OP_WHEEL  = 3'd3;
  localparam logic [2:0] OP_POP    = 3'd4;
  localparam logic [2:0] OP_DRAIN  = 3'd5;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_KEY_DOWN = 3'd1;
  localparam logic [2:0] EV_KEY_UP   = 3'd2;
  localparam logic [2:0] EV_MOVE     = 3'd3;
  localparam logic [2:0] EV_BUTTON   = 3'd4;
  localparam logic [2:0] EV_WHEEL    = 3'd5;

  localparam logic [1:0] RK_EVENT   = 2'd0;
  localparam logic [1:0] RK_EMPTY   = 2'd1;
  localparam logic [1:0] RK_SUMMARY = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KEYLIM = 2'd2;

  localparam logic [7:0] SC_LSHIFT = 8'h2A;
  localparam logic [7:0] SC_RSHIFT = 8'h36;
  localparam logic [7:0] SC_CTRL   = 8'h1D;
  localparam logic [7:0] SC_ALT    = 8'h38;

  localparam logic [2:0] MOD_SHIFT = 3'b001;
  localparam logic [2:0] MOD_CTRL  = 3'b010;
  localparam logic [2:0] MOD_ALT   = 3'b100;

  typedef struct packed {
    logic [2:0]         op_kind;
    logic [7:0]         scancode;
    logic               pressed;
    logic               extended;
    logic signed [15:0] move_dx;
    logic signed [15:0] move_dy;
    logic [7:0]         button_state;
    logic signed [15:0] wheel_delta;
    logic [63:0]        time_stamp;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [2:0]         event_type;
    logic [7:0]         key_code;
    logic [3:0]         event_flags;
    logic [7:0]         event_buttons;
    logic signed [15:0] delta_x_out;
    logic signed [15:0] delta_y_out;
    logic signed [15:0] wheel_out;
    logic [63:0]        event_time;
    logic [11:0]        cursor_x;
    logic [11:0]        cursor_y;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic        push;
    out_item_t   item;
  } res_push_t;

endpackage
`default_nettype wire

@@ rtl/core/iecq_front.sv @@
`default_nettype none
module iecq_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire iecq_pkg::in_item_t in_item_i,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [12:0]        cfg_data_i,
  input  wire logic               res_full_i,
  output iecq_pkg::res_push_t     res_o
);
  import iecq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_USE, S_SUM} state_e;

  typedef struct packed {
    logic [2:0]         ev_type;
    logic [7:0]         key_code;
    logic [3:0]         flags;
    logic [7:0]         buttons;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] wheel;
    logic [63:0]        tstamp;
  } entry_t;

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rdata_q;
  entry_t wentry;
  logic   wen;

  state_e     state_q;
  logic       drain_q;
  logic [PTR_W-1:0] wp_q, rp_q;
  logic [12:0] width_q, height_q;
  logic [5:0]  keylim_q;
  logic [11:0] px_q, py_q;
  logic [7:0]  held_q, ob_q;
  logic [2:0]  mods_q;
  logic [15:0] sx_q, sy_q, sw_q;
  logic [5:0]  nkeys_q;

  function automatic logic [12:0] bound(input logic [12:0] v);
    if (v == 13'd0) return 13'd1;
    if (v > 13'd4096) return 13'd4096;
    return v;
  endfunction

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [11:0] clamp_axis(input logic [11:0] pos,
                                             input logic signed [15:0] d,
                                             input logic [12:0] size);
    logic signed [17:0] v;
    logic [12:0] hi;
    v  = $signed({6'd0, pos}) + 18'(d);
    hi = bound(size) - 13'd1;
    if (v < 0) return 12'd0;
    if (v > $signed({5'd0, hi})) return hi[11:0];
    return v[11:0];
  endfunction

  logic [5:0] lim;
  assign lim = (keylim_q < 6'(MAX_KEYS)) ? keylim_q : 6'(MAX_KEYS);

  logic [12:0] cfg_bound;
  assign cfg_bound = bound(cfg_data_i);

  logic accept, empty;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept = in_valid_i && (state_q == S_IDLE);
  assign empty  = (rp_q == wp_q);

  logic [2:0] mod_bit;
  always_comb begin
    unique case (in_item_i.scancode)
      SC_LSHIFT, SC_RSHIFT: mod_bit = MOD_SHIFT;
      SC_CTRL:              mod_bit = MOD_CTRL;
      SC_ALT:               mod_bit = MOD_ALT;
      default:              mod_bit = 3'b000;
    endcase
  end

  always_comb begin
    wentry = '0;
    wentry.tstamp = in_item_i.time_stamp;
    wen = 1'b0;
    if (accept) begin
      unique case (in_item_i.op_kind)
        OP_KEY: begin
          wen = 1'b1;
          wentry.ev_type  = in_item_i.pressed ? EV_KEY_DOWN : EV_KEY_UP;
          wentry.key_code = in_item_i.scancode;
          wentry.flags    = {mods_q, in_item_i.extended};
        end
        OP_MOVE: begin
          wen = 1'b1;
          wentry.ev_type = EV_MOVE;
          wentry.buttons = held_q;
          wentry.dx      = in_item_i.move_dx;
          wentry.dy      = in_item_i.move_dy;
        end
        OP_BUTTON: begin
          wen = (in_item_i.button_state != held_q);
          wentry.ev_type = EV_BUTTON;
          wentry.buttons = in_item_i.button_state;
        end
        OP_WHEEL: begin
          wen = 1'b1;
          wentry.ev_type = EV_WHEEL;
          wentry.buttons = held_q;
          wentry.wheel   = in_item_i.wheel_delta;
        end
        default: wen = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) mem_q[wp_q] <= wentry;
    rdata_q <= mem_q[rp_q];
  end

  // Result beat: the entry read last cycle, an empty or a summary.
  logic key_entry, need_push;
  assign key_entry = (rdata_q.ev_type == EV_KEY_DOWN) || (rdata_q.ev_type == EV_KEY_UP);
  always_comb begin
    res_o = '0;
    res_o.item.cursor_x = px_q;
    res_o.item.cursor_y = py_q;
    need_push = 1'b0;
    if (state_q == S_SUM) begin
      need_push = 1'b1;
      res_o.item.result_kind   = RK_SUMMARY;
      res_o.item.event_flags   = {mods_q, 1'b0};
      res_o.item.event_buttons = ob_q;
      res_o.item.delta_x_out   = sx_q;
      res_o.item.delta_y_out   = sy_q;
      res_o.item.wheel_out     = sw_q;
      res_o.item.last_of_run   = 1'b1;
    end else if (state_q == S_USE) begin
      if (!drain_q && empty) begin
        need_push = 1'b1;
        res_o.item.result_kind = RK_EMPTY;
        res_o.item.last_of_run = 1'b1;
      end else if (!drain_q || (key_entry && nkeys_q < lim)) begin
        need_push = 1'b1;
        res_o.item.result_kind   = RK_EVENT;
        res_o.item.event_type    = rdata_q.ev_type;
        res_o.item.key_code      = rdata_q.key_code;
        res_o.item.event_flags   = rdata_q.flags;
        res_o.item.event_buttons = rdata_q.buttons;
        res_o.item.delta_x_out   = rdata_q.dx;
        res_o.item.delta_y_out   = rdata_q.dy;
        res_o.item.wheel_out     = rdata_q.wheel;
        res_o.item.event_time    = rdata_q.tstamp;
        res_o.item.last_of_run   = !drain_q;
      end
    end
    res_o.push = need_push && !res_full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      drain_q  <= 1'b0;
      wp_q     <= '0;
      rp_q     <= '0;
      width_q  <= 13'd640;
      height_q <= 13'd480;
      keylim_q <= 6'd32;
      px_q     <= 12'd320;
      py_q     <= 12'd240;
      held_q   <= '0;
      ob_q     <= '0;
      mods_q   <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
      sw_q     <= '0;
      nkeys_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WIDTH: begin
            width_q <= cfg_data_i;
            px_q    <= cfg_bound[12:1];
          end
          REG_HEIGHT: begin
            height_q <= cfg_data_i;
            py_q     <= cfg_bound[12:1];
          end
          REG_KEYLIM: keylim_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (wen) begin
        wp_q <= advance(wp_q);
        if (advance(wp_q) == rp_q) rp_q <= advance(rp_q);
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (in_item_i.op_kind)
              OP_KEY: begin
                if (in_item_i.pressed) mods_q <= mods_q | mod_bit;
                else mods_q <= mods_q & ~mod_bit;
              end
              OP_MOVE: begin
                px_q <= clamp_axis(px_q, in_item_i.move_dx, width_q);
                py_q <= clamp_axis(py_q, in_item_i.move_dy, height_q);
              end
              OP_BUTTON: held_q <= in_item_i.button_state;
              OP_POP: begin
                drain_q <= 1'b0;
                state_q <= S_READ;
              end
              OP_DRAIN: begin
                drain_q <= 1'b1;
                ob_q    <= held_q;
                sx_q    <= '0;
                sy_q    <= '0;
                sw_q    <= '0;
                nkeys_q <= '0;
                state_q <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          if (drain_q && empty) state_q <= S_SUM;
          else state_q <= S_USE;
        end
        S_USE: begin
          if (!need_push || !res_full_i) begin
            if (!empty) rp_q <= advance(rp_q);
            if (!drain_q) begin
              state_q <= S_IDLE;
            end else begin
              state_q <= S_READ;
              if (need_push) nkeys_q <= nkeys_q + 6'd1;
              if (rdata_q.ev_type == EV_MOVE) begin
                sx_q <= sx_q + rdata_q.dx;
                sy_q <= sy_q + rdata_q.dy;
              end
              if (rdata_q.ev_type == EV_BUTTON) ob_q <= rdata_q.buttons;
              if (rdata_q.ev_type == EV_WHEEL) sw_q <= sw_q + rdata_q.wheel;
            end
          end
        end
        S_SUM: begin
          if (!res_full_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/iecq_res_fifo.sv @@
`default_nettype none
module iecq_res_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire iecq_pkg::res_push_t res_i,
  output logic                     full_o,
  output logic                     nempty_o,
  input  wire logic                pop_i,
  output iecq_pkg::out_item_t      head_o
);
  import iecq_pkg::*;

  out_item_t buf_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_q, rd_q;
  logic [RES_PTR_W:0]   cnt_q;
  logic do_pop;

  assign full_o   = (cnt_q == (RES_PTR_W+1)'(RES_DEPTH));
  assign nempty_o = (cnt_q != '0);
  assign do_pop   = pop_i && nempty_o;
  assign head_o   = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (res_i.push) buf_q[wr_q] <= res_i.item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (res_i.push) wr_q <= wr_q + RES_PTR_W'(1);
      if (do_pop) rd_q <= rd_q + RES_PTR_W'(1);
      if (res_i.push && !do_pop) cnt_q <= cnt_q + (RES_PTR_W+1)'(1);
      else if (!res_i.push && do_pop) cnt_q <= cnt_q - (RES_PTR_W+1)'(1);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/iecq_back.sv @@
`default_nettype none
module iecq_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                nempty_i,
  input  wire iecq_pkg::out_item_t head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output iecq_pkg::out_item_t      out_item_o
);
  import iecq_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  // The output register reloads when empty or when its beat is taken.
  assign pop_o       = nempty_i && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) item_q <= head_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (!valid_q || !out_stall_i) valid_q <= nempty_i;
  end

endmodule
`default_nettype wire

@@ rtl/core/input_event_queue_coalescer_unit.sv @@
// Posted events are taken while idle; a pop or a drain stalls the input until
// its last result is queued. A drain reads the ring entry by entry, the read
// port being registered, and ends with a summary. Results leave through a
// four-entry queue and an output register, one beat a cycle while the receiver
// does not stall. Reset empties the ring, clears modifiers and buttons and centres
// the cursor on a 640 by 480 screen; ring contents are not cleared.
`default_nettype none
module input_event_queue_coalescer_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire iecq_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output iecq_pkg::out_item_t      out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [12:0]         cfg_data_i
);
  import iecq_pkg::*;

  res_push_t res;
  logic      full, nempty, pop;
  out_item_t head;

  iecq_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .res_full_i(full), .res_o(res)
  );

  iecq_res_fifo u_fifo (
    .clk_i, .rst_ni, .res_i(res), .full_o(full), .nempty_o(nempty),
    .pop_i(pop), .head_o(head)
  );

  iecq_back u_back (
    .clk_i, .rst_ni, .nempty_i(nempty), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_item_o
  );

endmodule
`default_nettype wire

@@ bench/input_event_queue_coalescer_unit_tb.sv @@
`default_nettype none
module input_event_queue_coalescer_unit_tb;
  import iecq_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [12:0] cfg_data_i = '0;

  input_event_queue_coalescer_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the block's state.
  logic [4:0]  wr_ptr, rd_ptr;
  out_item_t   ring [QUEUE_DEPTH];
  logic [11:0] cur_x, cur_y;
  logic [7:0]  held_btn;
  logic [2:0]  mods;
  logic [12:0] scr_w, scr_h;
  logic [5:0]  key_lim;

  out_item_t expected_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int drains_done = 0;
  int idle_pct = 33;
  int stall_pct = 33;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  function automatic int clip_size(logic [12:0] v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return int'(v);
  endfunction

  function automatic logic [11:0] move_axis(logic [11:0] pos, logic signed [15:0] d,
                                            logic [12:0] size);
    int v;
    v = int'(pos) + int'(d);
    if (v < 0) v = 0;
    if (v > clip_size(size) - 1) v = clip_size(size) - 1;
    return v[11:0];
  endfunction

  function automatic void push_event(out_item_t e);
    logic [4:0] nxt;
    nxt = wr_ptr + 5'd1;
    if (nxt == rd_ptr) rd_ptr = rd_ptr + 5'd1;
    ring[wr_ptr] = e;
    wr_ptr = nxt;
  endfunction

  function automatic void reset_shadow();
    wr_ptr = '0; rd_ptr = '0;
    scr_w = 13'd640; scr_h = 13'd480; key_lim = 6'd32;
    cur_x = 12'd320; cur_y = 12'd240;
    held_btn = '0; mods = '0;
  endfunction

  function automatic void set_register(logic [1:0] idx, logic [12:0] v);
    case (idx)
      REG_WIDTH: begin
        scr_w = v; cur_x = 12'(clip_size(v) / 2);
      end
      REG_HEIGHT: begin
        scr_h = v; cur_y = 12'(clip_size(v) / 2);
      end
      REG_KEYLIM: key_lim = v[5:0];
      default: ;
    endcase
  endfunction

  // Works out the results of one accepted item and queues them.
  function automatic void predict_item(in_item_t it);
    out_item_t e, r;
    logic [2:0] m;
    logic [15:0] sx, sy, sw;
    logic [7:0] ob;
    int n, lim;
    e = '0;
    case (it.op_kind)
      OP_KEY: begin
        e.event_type = it.pressed ? EV_KEY_DOWN : EV_KEY_UP;
        e.key_code = it.scancode;
        e.event_flags = {mods, it.extended};
        e.event_time = it.time_stamp;
        push_event(e);
        m = '0;
        if (it.scancode == SC_LSHIFT || it.scancode == SC_RSHIFT) m = MOD_SHIFT;
        else if (it.scancode == SC_CTRL) m = MOD_CTRL;
        else if (it.scancode == SC_ALT) m = MOD_ALT;
        if (it.pressed) mods = mods | m; else mods = mods & ~m;
      end
      OP_MOVE: begin
        cur_x = move_axis(cur_x, it.move_dx, scr_w);
        cur_y = move_axis(cur_y, it.move_dy, scr_h);
        e.event_type = EV_MOVE;
        e.event_buttons = held_btn;
        e.delta_x_out = it.move_dx;
        e.delta_y_out = it.move_dy;
        e.event_time = it.time_stamp;
        push_event(e);
      end
      OP_BUTTON: begin
        if (it.button_state != held_btn) begin
          held_btn = it.button_state;
          e.event_type = EV_BUTTON;
          e.event_buttons = it.button_state;
          e.event_time = it.time_stamp;
          push_event(e);
        end
      end
      OP_WHEEL: begin
        e.event_type = EV_WHEEL;
        e.event_buttons = held_btn;
        e.wheel_out = it.wheel_delta;
        e.event_time = it.time_stamp;
        push_event(e);
      end
      OP_POP: begin
        if (rd_ptr == wr_ptr) begin
          r = '0;
          r.result_kind = RK_EMPTY;
        end else begin
          r = ring[rd_ptr];
          r.result_kind = RK_EVENT;
          rd_ptr = rd_ptr + 5'd1;
        end
        r.cursor_x = cur_x; r.cursor_y = cur_y; r.last_of_run = 1'b1;
        expected_results.push_back(r);
      end
      OP_DRAIN: begin
        lim = (key_lim < MAX_KEYS) ? int'(key_lim) : int'(MAX_KEYS);
        sx = '0; sy = '0; sw = '0; ob = held_btn; n = 0;
        while (rd_ptr != wr_ptr) begin
          r = ring[rd_ptr];
          case (r.event_type)
            EV_MOVE: begin
              sx = sx + r.delta_x_out; sy = sy + r.delta_y_out;
            end
            EV_BUTTON: ob = r.event_buttons;
            EV_WHEEL: sw = sw + r.wheel_out;
            EV_KEY_DOWN, EV_KEY_UP: begin
              if (n < lim) begin
                r.result_kind = RK_EVENT;
                r.cursor_x = cur_x; r.cursor_y = cur_y; r.last_of_run = 1'b0;
                expected_results.push_back(r);
                n++;
              end
            end
            default: ;
          endcase
          rd_ptr = rd_ptr + 5'd1;
        end
        r = '0;
        r.result_kind = RK_SUMMARY;
        r.event_flags = {mods, 1'b0};
        r.event_buttons = ob;
        r.delta_x_out = sx; r.delta_y_out = sy; r.wheel_out = sw;
        r.cursor_x = cur_x; r.cursor_y = cur_y; r.last_of_run = 1'b1;
        expected_results.push_back(r);
        drains_done++;
      end
      default: ;
    endcase
  endfunction

  // Valid stays high after the beat is taken; the next call or idle_input drives it.
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_item(it);
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, or a held stall when a hold-off is asked for.
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_item_o);
      end else begin
        out_item_t x;
        x = expected_results.pop_front();
        if (x !== out_item_o) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", x, out_item_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("[input_event_queue_coalescer_unit] ERROR");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [2:0] op);
    in_item_t it;
    it = '0;
    it.op_kind = op;
    it.scancode = 8'($urandom);
    case ($urandom_range(5))
      0: it.scancode = SC_LSHIFT;
      1: it.scancode = SC_RSHIFT;
      2: it.scancode = SC_CTRL;
      3: it.scancode = SC_ALT;
      default: ;
    endcase
    it.pressed = 1'($urandom);
    it.extended = 1'($urandom);
    it.move_dx = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40) - 20);
    it.move_dy = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40) - 20);
    it.button_state = ($urandom_range(1) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
    it.wheel_delta = 16'($urandom);
    it.time_stamp = {$urandom, $urandom};
    return it;
  endfunction

  function automatic logic [2:0] random_op();
    int p;
    p = $urandom_range(99);
    if (p < 30) return OP_KEY;
    if (p < 50) return OP_MOVE;
    if (p < 62) return OP_BUTTON;
    if (p < 72) return OP_WHEEL;
    if (p < 86) return OP_POP;
    if (p < 96) return OP_DRAIN;
    return 3'($urandom_range(7, 6));
  endfunction

  task automatic wait_idle();
    idle_input();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Write enable stays high; the caller drops it after the last write.
  task automatic write_register(logic [1:0] idx, logic [12:0] v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    set_register(idx, v);
  endtask

  task automatic test_directed();
    in_item_t it;
    it = make_item(OP_POP);
    send_item(it);
    it = make_item(OP_DRAIN);
    send_item(it);
    // Modifier keys pressed and released, extremes of the fields.
    it = make_item(OP_KEY); it.scancode = SC_LSHIFT; it.pressed = 1'b1; send_item(it);
    it = make_item(OP_KEY); it.scancode = SC_CTRL; it.pressed = 1'b1; send_item(it);
    it = make_item(OP_KEY); it.scancode = SC_ALT; it.pressed = 1'b1; send_item(it);
    it = make_item(OP_KEY); it.scancode = 8'hFF; it.extended = 1'b1;
    it.time_stamp = '1; send_item(it);
    it = make_item(OP_KEY); it.scancode = SC_RSHIFT; it.pressed = 1'b0; send_item(it);
    it = make_item(OP_MOVE); it.move_dx = 16'sh7FFF; it.move_dy = 16'sh7FFF; send_item(it);
    it = make_item(OP_MOVE); it.move_dx = 16'sh8000; it.move_dy = 16'sh8000; send_item(it);
    it = make_item(OP_BUTTON); it.button_state = 8'hFF; send_item(it);
    it = make_item(OP_BUTTON); it.button_state = 8'hFF; send_item(it);
    it = make_item(OP_WHEEL); it.wheel_delta = 16'sh8000; send_item(it);
    it = make_item(OP_WHEEL); it.wheel_delta = 16'sh7FFF; send_item(it);
    it = make_item(3'd6); send_item(it);
    it = make_item(3'd7); send_item(it);
    it = make_item(OP_POP); send_item(it);
    it = make_item(OP_DRAIN); send_item(it);
    it = make_item(OP_BUTTON); it.button_state = 8'h00; send_item(it);
    it = make_item(OP_POP); send_item(it);
    it = make_item(OP_POP); send_item(it);
  endtask

  task automatic test_ring_overflow();
    in_item_t it;
    for (int i = 0; i < 40; i++) begin
      it = make_item(OP_KEY);
      send_item(it);
    end
    it = make_item(OP_DRAIN);
    send_item(it);
  endtask

  task automatic test_random(int count);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      it = make_item(random_op());
      send_item(it);
    end
  endtask

  task automatic test_registers(logic [12:0] w, logic [12:0] h, logic [5:0] k);
    wait_idle();
    write_register(REG_WIDTH, w);
    write_register(REG_HEIGHT, h);
    write_register(REG_KEYLIM, 13'(k));
    cfg_we_i <= 1'b0;
    test_random(6);
    test_ring_overflow();
  endtask

  task automatic test_backpressure();
    in_item_t it;
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++) begin
          it = make_item(($urandom_range(1) == 0) ? OP_POP : OP_DRAIN);
          send_item(it);
        end
        idle_input();
      end
    join
  endtask

  initial begin
    reset_shadow();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_ring_overflow();
    test_random(60);
    test_backpressure();
    // Long stretch with neither side idling.
    idle_pct = 0; stall_pct = 0;
    test_random(50);
    idle_pct = 33; stall_pct = 33;
    test_registers(13'd1, 13'd1, 6'd0);
    test_registers(13'd4096, 13'd4096, 6'd63);
    test_registers(13'd0, 13'd8191, 6'd3);
    test_registers(13'd100, 13'd37, 6'd32);
    wait_idle();
    $display("Covered %0d result beats and %0d drains over all ops, ring overflow,",
             results_seen, drains_done);
    $display("several screen sizes and key limits, and a long receiver hold-off.");
    if (mismatches == 0) begin
      $display("[input_event_queue_coalescer_unit] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[input_event_queue_coalescer_unit] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
